// ===== sv/ordered_array_list_engine_top_assert.svh =====
// Assertion macros for the ordered array list engine top level.
// Needs clk and rst_n in scope at the point of use.
`ifndef ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define OALE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oale: same-cycle check failed");

// next-cycle implication
`define OALE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oale: next-cycle check failed");

`endif

// ===== sv/oale_pkg.sv =====
// Shared types and constants for the ordered array list engine.
// No dependencies.
`timescale 1ns / 1ps

package oale_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic [4:0]         position;
        logic signed [31:0] word_in;
    } req_t;

    typedef struct packed {
        logic signed [31:0] word_out;
        logic [4:0]         element_count;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ===== sv/oale_ctrl.sv =====
// Controller for the ordered array list engine: accepts a request beat,
// then runs the execute step in the datapath. Depends on oale_pkg.
`timescale 1ns / 1ps

module oale_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output oale_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/oale_datapath.sv =====
// Datapath for the ordered array list engine: request register, a row of
// shifting word cells, the element count and the result register.
// Depends on oale_pkg.
`timescale 1ns / 1ps

module oale_datapath #(
    parameter int DEPTH = oale_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  oale_pkg::cmd_t    cmd,
    input  oale_pkg::req_t    req,
    output logic              done,
    output oale_pkg::rsp_t    rsp
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    oale_pkg::req_t     req_reg;
    oale_pkg::rsp_t     rsp_reg;
    oale_pkg::rsp_t     rsp_next;
    logic               done_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] store_reg  [DEPTH];
    logic signed [31:0] store_next [DEPTH];

    logic [CMPW-1:0]    pos_w;
    logic [CMPW-1:0]    cnt_w;
    logic [CMPW-1:0]    ins_w;
    logic [CMPW-1:0]    depth_w;
    logic               do_write;
    logic               do_ins;
    logic               do_rem;
    logic signed [31:0] rd_word;
    logic [1:0]         st;

    always_comb
    begin
        pos_w    = CMPW'(req_reg.position);
        cnt_w    = CMPW'(count_reg);
        depth_w  = CMPW'(DEPTH);
        ins_w    = pos_w;
        do_write = 1'b0;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        rd_word  = '0;
        st       = oale_pkg::ST_OK;
        case (req_reg.op)
            oale_pkg::OP_READ:
            begin
                if (pos_w < cnt_w)
                    rd_word = store_reg[pos_w[IW-1:0]];
                else
                    st = oale_pkg::ST_RANGE;
            end
            oale_pkg::OP_WRITE:
            begin
                if (pos_w < cnt_w)
                    do_write = 1'b1;
                else
                    st = oale_pkg::ST_RANGE;
            end
            oale_pkg::OP_APPEND:
            begin
                ins_w = cnt_w;
                if (cnt_w >= depth_w)
                    st = oale_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            oale_pkg::OP_INSERT:
            begin
                if (pos_w > cnt_w)
                    st = oale_pkg::ST_RANGE;
                else if (cnt_w >= depth_w)
                    st = oale_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            oale_pkg::OP_REMOVE:
            begin
                if (pos_w < cnt_w)
                    do_rem = 1'b1;
                else
                    st = oale_pkg::ST_RANGE;
            end
            default:
            begin
                st = oale_pkg::ST_RANGE;
            end
        endcase

        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CW'(1);
        else if (do_rem)
            count_next = count_reg - CW'(1);

        rsp_next.word_out      = rd_word;
        rsp_next.element_count = 5'(count_next);
        rsp_next.status        = st;
    end

    // each cell picks from itself, its lower or upper neighbor, or the new word
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        if (k > 0)
        begin : g_lo
            assign lower = store_reg[k-1];
        end
        else
        begin : g_lo0
            assign lower = store_reg[k];
        end
        if (k < DEPTH - 1)
        begin : g_up
            assign upper = store_reg[k+1];
        end
        else
        begin : g_upn
            assign upper = store_reg[k];
        end

        always_comb
        begin
            store_next[k] = store_reg[k];
            if (do_write && (CMPW'(k) == pos_w))
                store_next[k] = req_reg.word_in;
            else if (do_ins && (CMPW'(k) == ins_w))
                store_next[k] = req_reg.word_in;
            else if (do_ins && (CMPW'(k) > ins_w))
                store_next[k] = lower;
            else if (do_rem && (CMPW'(k) >= pos_w))
                store_next[k] = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
        begin
            rsp_reg   <= rsp_next;
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
                count_reg <= count_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/ordered_array_list_engine_top.sv =====
// Ordered array list engine: bounded list of signed words with read,
// overwrite, append, insert and remove.
// Request channel: req is taken at a rising edge where start is high and
//   busy is low. busy stays high while the controller executes that beat.
// Result channel: done marks rsp for exactly one cycle; the receiver takes
//   it on the edge that ends that cycle and cannot stall it.
// Result path: req is registered at the accepting edge, then rsp and done
//   are registered at the end of the execute cycle. A new request is taken
//   only once the controller is back in idle; every cell that shifts does
//   so in that execute cycle.
// Reset: rst_n (async, active low) empties the list and returns the
//   controller to idle; stored words are not cleared and are never read
//   before they are written.
// Status codes: ok, position out of range, list full. Failed requests
//   change nothing and return zero in word_out.
// Depends on oale_pkg, oale_ctrl, oale_datapath and the assertion header.
`timescale 1ns / 1ps

`include "ordered_array_list_engine_top_assert.svh"

module ordered_array_list_engine_top #(
    parameter int DEPTH = oale_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  oale_pkg::req_t    req,
    output logic              done,
    output oale_pkg::rsp_t    rsp
);

    oale_pkg::cmd_t cmd;

    oale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    oale_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    `OALE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `OALE_ASSERT_NOW(a_done_idle, done, !busy)
    `OALE_ASSERT_NOW(a_fail_zero, done && (rsp.status != oale_pkg::ST_OK), rsp.word_out == 32'sd0)
    `OALE_ASSERT_NEXT(a_exec_done, cmd.exec, done)

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for ordered_array_list_engine_top: directed corner cases, a full-list test
// and a long random mix, all checked against an in-bench list model.
// Depends on oale_pkg and ordered_array_list_engine_top.
`timescale 1ns / 1ps

module tb;

    localparam int LIST_DEPTH = oale_pkg::DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 400;
    localparam int RANDOM_BEATS = 1850;
    localparam int MAX_PRINTS = 20;

    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    oale_pkg::req_t req;
    logic           done;
    oale_pkg::rsp_t rsp;

    // list model
    logic signed [31:0] list_words [LIST_DEPTH];
    int                 list_len;

    oale_pkg::rsp_t expected_rsps [$];
    oale_pkg::rsp_t want_rsp;

    bit allow_gaps;
    int fail_count;
    int beats_sent;
    int results_checked;
    int ok_seen;
    int range_seen;
    int full_seen;
    int peak_len;
    int idle_cycles;

    ordered_array_list_engine_top #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic oale_pkg::rsp_t apply_list_op(input oale_pkg::req_t r);
        oale_pkg::rsp_t o;
        int             where;
        int             k;
        o = '0;
        o.status = oale_pkg::ST_OK;
        case (r.op)
            oale_pkg::OP_READ:
            begin
                if (r.position < list_len)
                    o.word_out = list_words[r.position];
                else
                    o.status = oale_pkg::ST_RANGE;
            end
            oale_pkg::OP_WRITE:
            begin
                if (r.position < list_len)
                    list_words[r.position] = r.word_in;
                else
                    o.status = oale_pkg::ST_RANGE;
            end
            oale_pkg::OP_APPEND, oale_pkg::OP_INSERT:
            begin
                where = (r.op == oale_pkg::OP_APPEND) ? list_len : int'(r.position);
                if (r.op == oale_pkg::OP_INSERT && where > list_len)
                    o.status = oale_pkg::ST_RANGE;
                else if (list_len >= LIST_DEPTH)
                    o.status = oale_pkg::ST_FULL;
                else
                begin
                    for (k = list_len; k > where; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[where] = r.word_in;
                    list_len++;
                end
            end
            oale_pkg::OP_REMOVE:
            begin
                if (r.position < list_len)
                begin
                    for (k = r.position; k + 1 < list_len; k++)
                        list_words[k] = list_words[k + 1];
                    list_len--;
                end
                else
                    o.status = oale_pkg::ST_RANGE;
            end
            default:
                o.status = oale_pkg::ST_RANGE;
        endcase
        o.element_count = list_len[4:0];
        case (o.status)
            oale_pkg::ST_OK:    ok_seen++;
            oale_pkg::ST_RANGE: range_seen++;
            default:            full_seen++;
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return oale_pkg::OP_READ;
        else if (r < 35)
            return oale_pkg::OP_WRITE;
        else if (r < 95)
        begin
            if (grow)
                return (r < 60) ? oale_pkg::OP_APPEND :
                       (r < 85) ? oale_pkg::OP_INSERT : oale_pkg::OP_REMOVE;
            else
                return (r < 45) ? oale_pkg::OP_APPEND :
                       (r < 55) ? oale_pkg::OP_INSERT : oale_pkg::OP_REMOVE;
        end
        case ($urandom_range(0, 2))
            0:       return OP_RSVD_5;
            1:       return OP_RSVD_6;
            default: return OP_RSVD_7;
        endcase
    endfunction

    function automatic int pick_position(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            if (op == oale_pkg::OP_INSERT)
                return $urandom_range(0, list_len);
            return (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
        end
        else if (r < 85)
            return list_len;
        return $urandom_range(0, 31);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got 0x%08h, expected 0x%08h",
                     $time, what, got, want);
    endtask

    // one request beat; the model is updated at the accepting edge
    task automatic send_op(input logic [2:0] op, input int pos, input logic [31:0] w);
        oale_pkg::req_t r;
        int             gap;
        r.op = op;
        r.position = pos[4:0];
        r.word_in = w;
        gap = allow_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        expected_rsps.push_back(apply_list_op(r));
        beats_sent++;
    endtask

    task automatic test_corner_cases();
        send_op(oale_pkg::OP_READ, 0, 32'h1);
        send_op(oale_pkg::OP_READ, 31, 32'h2);
        send_op(oale_pkg::OP_WRITE, 0, 32'h3);
        send_op(oale_pkg::OP_REMOVE, 0, 32'h4);
        send_op(oale_pkg::OP_INSERT, 1, 32'h5);
        send_op(oale_pkg::OP_INSERT, 0, 32'h7fff_ffff);
        send_op(oale_pkg::OP_APPEND, 17, 32'h8000_0000);
        send_op(oale_pkg::OP_APPEND, 0, 32'h0000_0000);
        send_op(oale_pkg::OP_APPEND, 0, 32'hffff_ffff);
        send_op(oale_pkg::OP_INSERT, 1, 32'h0000_3039);
        send_op(oale_pkg::OP_INSERT, 5, 32'haaaa_aaaa);
        send_op(oale_pkg::OP_READ, 0, 32'h0);
        send_op(oale_pkg::OP_READ, 5, 32'h0);
        send_op(oale_pkg::OP_READ, 6, 32'h0);
        send_op(oale_pkg::OP_WRITE, 2, 32'h5555_5555);
        send_op(oale_pkg::OP_WRITE, 6, 32'h1234_5678);
        send_op(oale_pkg::OP_READ, 2, 32'h0);
        send_op(oale_pkg::OP_REMOVE, 1, 32'h0);
        send_op(oale_pkg::OP_REMOVE, 4, 32'h0);
        send_op(oale_pkg::OP_REMOVE, 4, 32'h0);
        send_op(OP_RSVD_5, 0, 32'hffff_ffff);
        send_op(OP_RSVD_6, 1, 32'h0);
        send_op(OP_RSVD_7, 31, 32'hffff_ffff);
        send_op(oale_pkg::OP_READ, 3, 32'h0);
    endtask

    task automatic test_full_list();
        while (list_len < LIST_DEPTH)
        begin
            if ($urandom_range(0, 1))
                send_op(oale_pkg::OP_APPEND, $urandom_range(0, 31), pick_word());
            else
                send_op(oale_pkg::OP_INSERT, $urandom_range(0, list_len), pick_word());
        end
        send_op(oale_pkg::OP_APPEND, 0, pick_word());
        send_op(oale_pkg::OP_INSERT, 0, pick_word());
        send_op(oale_pkg::OP_INSERT, LIST_DEPTH, pick_word());
        send_op(oale_pkg::OP_INSERT, LIST_DEPTH + 1, pick_word());
        send_op(oale_pkg::OP_INSERT, 31, pick_word());
        send_op(oale_pkg::OP_READ, LIST_DEPTH - 1, 32'h0);
        send_op(oale_pkg::OP_READ, LIST_DEPTH, 32'h0);
        send_op(oale_pkg::OP_WRITE, LIST_DEPTH - 1, pick_word());
        send_op(oale_pkg::OP_READ, LIST_DEPTH - 1, 32'h0);
        send_op(oale_pkg::OP_REMOVE, LIST_DEPTH - 1, 32'h0);
        send_op(oale_pkg::OP_APPEND, 0, pick_word());
        send_op(oale_pkg::OP_REMOVE, 0, 32'h0);
        while (list_len > 0)
        begin
            if ($urandom_range(0, 2) == 0)
                send_op(oale_pkg::OP_READ, $urandom_range(0, list_len - 1), 32'h0);
            send_op(oale_pkg::OP_REMOVE, $urandom_range(0, list_len - 1), 32'h0);
        end
        send_op(oale_pkg::OP_REMOVE, 0, 32'h0);
        send_op(oale_pkg::OP_READ, 0, 32'h0);
    endtask

    // length drifts up and down so both the empty and the full list get hit
    task automatic test_random_mix(input int n);
        int         i;
        bit         grow;
        logic [2:0] op;
        grow = 1'b1;
        for (i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                allow_gaps = ($urandom_range(0, 3) != 0);
            if (list_len == LIST_DEPTH && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            else if (list_len == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                grow = !grow;
            op = pick_op(grow);
            send_op(op, pick_position(op), pick_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("result with nothing pending", rsp.word_out, 32'h0);
            else
            begin
                want_rsp = expected_rsps.pop_front();
                results_checked++;
                if (rsp.word_out !== want_rsp.word_out)
                    report_mismatch("word_out", rsp.word_out, want_rsp.word_out);
                if (rsp.element_count !== want_rsp.element_count)
                    report_mismatch("element_count", 32'(rsp.element_count),
                                    32'(want_rsp.element_count));
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles, %0d results pending",
                     IDLE_LIMIT, expected_rsps.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        list_len = 0;
        allow_gaps = 1'b1;
        fail_count = 0;
        beats_sent = 0;
        results_checked = 0;
        ok_seen = 0;
        range_seen = 0;
        full_seen = 0;
        peak_len = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_full_list();
        test_random_mix(RANDOM_BEATS);

        start <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d requests, %0d results checked, list length peaked at %0d of %0d.",
                 beats_sent, results_checked, peak_len, LIST_DEPTH);
        $display("Status mix: %0d ok, %0d out of range, %0d full; %0d mismatches.",
                 ok_seen, range_seen, full_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
